@@ rtl/job_generation_barrier_core_macros.svh @@
// Assertion macros for the barrier RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef JOB_GENERATION_BARRIER_CORE_MACROS_SVH
`define JOB_GENERATION_BARRIER_CORE_MACROS_SVH

// same-cycle implication
`define JGB_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JGB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jgb_pkg.sv @@
// Package for the job generation barrier: payload structs, command/status codes
// and default sizes. No dependencies.
`timescale 1ns / 1ps

package jgb_pkg;

    localparam int MAX_JOBS_DEF    = 16;
    localparam int ROUND_WIDTH_DEF = 32;
    localparam int JOB_ID_W        = 4;
    localparam int ROUND_OUT_W     = 32;
    localparam int PEND_OUT_W      = 5;

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_POST   = 2'd1,
        CMD_ADD    = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_DUP     = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                cmd;
        logic [JOB_ID_W-1:0] job_id;
    } t_req;

    typedef struct packed {
        logic                   inhibited;
        logic                   released;
        logic [ROUND_OUT_W-1:0] round_number;
        logic [PEND_OUT_W-1:0]  pending_count;
        t_status                status;
    } t_rsp;

    // registered command transaction handed to the state stage
    typedef struct packed {
        logic valid;
        t_req req;
    } t_cmd_xact;

endpackage

@@ rtl/jgb_cmd_reg.sv @@
// Input register stage: captures one command transaction per accepted start.
// Depends on jgb_pkg.
`timescale 1ns / 1ps

module jgb_cmd_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  jgb_pkg::t_req     i_req,
    output jgb_pkg::t_cmd_xact o_xact
);

    logic          r_valid;
    jgb_pkg::t_req r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_req <= i_req;
        end
    end

    assign o_xact.valid = r_valid;
    assign o_xact.req   = r_req;

endmodule

@@ rtl/jgb_barrier_state.sv @@
// Barrier state (membership, arrival marks, round, pending and member counts)
// and the single-pass update for one command. Depends on jgb_pkg.
`timescale 1ns / 1ps

module jgb_barrier_state #(
    parameter int MAX_JOBS    = jgb_pkg::MAX_JOBS_DEF,
    parameter int ROUND_WIDTH = jgb_pkg::ROUND_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jgb_pkg::t_cmd_xact i_xact,
    output jgb_pkg::t_rsp      o_rsp
);

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    logic [MAX_JOBS-1:0]    r_member, n_member;
    logic [MAX_JOBS-1:0]    r_arrived, n_arrived;
    logic [ROUND_WIDTH-1:0] r_round, n_round;
    logic [CNT_W-1:0]       r_pending, n_pending;
    logic [CNT_W-1:0]       r_count, n_count;

    logic [IDX_W-1:0]       w_idx;
    logic                   w_in_range;
    logic                   w_is_member;
    logic                   w_arrived;
    logic [CNT_W-1:0]       w_pend_dec;
    logic                   w_released;
    jgb_pkg::t_status       w_status;
    logic [63:0]            w_round_ext;

    assign w_idx       = IDX_W'(i_xact.req.job_id);
    assign w_in_range  = 32'(i_xact.req.job_id) < 32'(MAX_JOBS);
    assign w_is_member = w_in_range && r_member[w_idx];
    assign w_arrived   = w_in_range && r_arrived[w_idx];
    // saturating decrement; zero is not reachable in practice
    assign w_pend_dec  = (r_pending != '0) ? r_pending - CNT_W'(1) : r_pending;

    always_comb begin
        n_member   = r_member;
        n_arrived  = r_arrived;
        n_round    = r_round;
        n_pending  = r_pending;
        n_count    = r_count;
        w_status   = jgb_pkg::ST_OK;
        w_released = 1'b0;
        if (i_xact.req.cmd == jgb_pkg::CMD_ADD) begin
            if (!w_in_range) begin
                w_status = jgb_pkg::ST_UNKNOWN;
            end else if (w_is_member) begin
                w_status = jgb_pkg::ST_DUP;
            end else begin
                n_member[w_idx]  = 1'b1;
                n_arrived[w_idx] = 1'b0;
                n_count          = r_count + CNT_W'(1);
                n_pending        = r_pending + CNT_W'(1);
            end
        end else if (!w_is_member) begin
            w_status = jgb_pkg::ST_UNKNOWN;
        end else begin
            case (i_xact.req.cmd)
                jgb_pkg::CMD_POST: begin
                    if (!w_arrived) begin
                        if (w_pend_dec == '0) begin
                            // last arrival: next round, everyone pending again
                            n_arrived  = '0;
                            n_pending  = r_count;
                            n_round    = r_round + ROUND_WIDTH'(1);
                            w_released = 1'b1;
                        end else begin
                            n_arrived[w_idx] = 1'b1;
                            n_pending        = w_pend_dec;
                        end
                    end
                end
                jgb_pkg::CMD_REMOVE: begin
                    if (!w_arrived) begin
                        n_pending = w_pend_dec;
                    end
                    n_member[w_idx]  = 1'b0;
                    n_arrived[w_idx] = 1'b0;
                    n_count = (r_count != '0) ? r_count - CNT_W'(1) : r_count;
                end
                default: begin
                    // query leaves state alone
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member  <= '0;
            r_arrived <= '0;
            r_round   <= '0;
            r_pending <= '0;
            r_count   <= '0;
        end else if (i_xact.valid) begin
            r_member  <= n_member;
            r_arrived <= n_arrived;
            r_round   <= n_round;
            r_pending <= n_pending;
            r_count   <= n_count;
        end
    end

    assign w_round_ext = 64'(n_round);

    assign o_rsp.inhibited     = w_in_range && n_member[w_idx] && n_arrived[w_idx];
    assign o_rsp.released      = w_released;
    assign o_rsp.round_number  = w_round_ext[jgb_pkg::ROUND_OUT_W-1:0];
    assign o_rsp.pending_count = jgb_pkg::PEND_OUT_W'(n_pending);
    assign o_rsp.status        = w_status;

endmodule

@@ rtl/job_generation_barrier_core.sv @@
// Top level of the job generation barrier: input register, state update and
// result register. Depends on jgb_pkg, jgb_cmd_reg, jgb_barrier_state and the macros header.
`timescale 1ns / 1ps
//
// Usage:
//   Command channel: drive i_req (cmd, job_id) and pulse start. A command is
//   taken on any clock edge where start is high and busy is low; busy stays
//   low, so a command can be issued every cycle.
//   Result channel: o_result_valid is high for exactly one cycle with o_rsp
//   (inhibited, released, round_number, pending_count, status). The result
//   cannot be held off; the receiver must take it in that cycle.
//   Result path: a command passes through the input register, then the state
//   update into the result register, which drives the strobe and o_rsp.
//   Throughput: one command per cycle; the state update for a command completes
//   in the cycle it leaves the input register, so the next command sees it.
//   Reset (synchronous, i_rst_n low): no members, no arrival marks, round zero,
//   pending zero; in-flight commands are dropped and no strobe is issued.
//
`include "job_generation_barrier_core_macros.svh"

module job_generation_barrier_core #(
    parameter int MAX_JOBS    = jgb_pkg::MAX_JOBS_DEF,
    parameter int ROUND_WIDTH = jgb_pkg::ROUND_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  jgb_pkg::t_req i_req,
    output logic          o_result_valid,
    output jgb_pkg::t_rsp o_rsp
);

    jgb_pkg::t_cmd_xact w_xact;
    jgb_pkg::t_rsp      w_rsp;
    logic               w_accept;
    logic               r_rsp_valid;
    jgb_pkg::t_rsp      r_rsp;
    logic               w_rsp_unknown;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    jgb_cmd_reg u_cmd_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_req   (i_req),
        .o_xact  (w_xact)
    );

    jgb_barrier_state #(
        .MAX_JOBS   (MAX_JOBS),
        .ROUND_WIDTH(ROUND_WIDTH)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_xact  (w_xact),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= w_xact.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xact.valid) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_result_valid = r_rsp_valid;
    assign o_rsp          = r_rsp;

    assign w_rsp_unknown = o_result_valid && (o_rsp.status == jgb_pkg::ST_UNKNOWN);

    `JGB_ASSERT_NEXT(a_one_result, w_xact.valid, o_result_valid, "command produced no result")
    `JGB_ASSERT(a_rel_clr, o_result_valid && o_rsp.released, !o_rsp.inhibited, "mark left set")
    `JGB_ASSERT(a_unk_idle, w_rsp_unknown, !o_rsp.inhibited && !o_rsp.released, "unknown job acted")
    `JGB_ASSERT(a_pend_max, o_result_valid, 32'(o_rsp.pending_count) <= MAX_JOBS, "pend > max")

endmodule
